// ===== src/lrnu_pkg.sv =====
// Shared definitions for the leaky rate neuron update block.
// Field widths, register and mode codes, and the logistic sample builder.
// No dependencies.
package lrnu_pkg;

  localparam int NEURON_COUNT_DEF        = 256;
  localparam int SIGMOID_TABLE_DEPTH_DEF = 256;

  localparam int ID_W      = 8;
  localparam int Q_W       = 16;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACT_MODE  = 3'd0,
    REG_GAIN      = 3'd1,
    REG_BIAS      = 3'd2,
    REG_SIG_MID   = 3'd3,
    REG_MIN_RATE  = 3'd4,
    REG_MAX_RATE  = 3'd5,
    REG_INIT_RATE = 3'd6,
    REG_DECAY     = 3'd7
  } cfg_reg_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_LINEAR  = 2'd0,
    MODE_RELU    = 2'd1,
    MODE_SIGMOID = 2'd2
  } act_mode_t;

  typedef struct packed {
    logic [MODE_W-1:0]    act_mode;
    logic signed [Q_W-1:0] gain;
    logic signed [Q_W-1:0] bias;
    logic signed [Q_W-1:0] sig_mid;
    logic signed [Q_W-1:0] min_rate;
    logic signed [Q_W-1:0] max_rate;
    logic signed [Q_W-1:0] init_rate;
    logic [Q_W-1:0]        decay;
  } cfg_t;

  // Shift-subtract division, used only while building constant tables.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    int b;
    q = '0;
    r = '0;
    for (b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // 1/(1+e^x), x = 16*m/depth, as floored Q0.16.
  function automatic logic [15:0] logistic_sample(input int m, input int depth);
    logic [63:0] one;
    logic [63:0] am;
    logic [63:0] u;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] f;
    int n;
    int i;
    one  = 64'(1) << 30;
    am   = (m < 0) ? 64'(-m) : 64'(m);
    u    = udiv64(am << 30, 64'(depth));
    sum  = one;
    term = one;
    for (n = 1; n <= 24; n++) begin
      term = udiv64((term * u) >> 30, 64'(n));
      sum  = sum + term;
    end
    e = udiv64(64'(1) << 60, sum);
    for (i = 0; i < 4; i++) begin
      e = (e * e) >> 30;
    end
    if (m >= 0) begin
      f = udiv64(e << 16, one + e);
    end else begin
      f = udiv64(64'(1) << 46, one + e);
    end
    if (f > 64'd65535) begin
      f = 64'd65535;
    end
    return f[15:0];
  endfunction

endpackage

// ===== src/leaky_rate_neuron_update_top.sv =====
// Leaky rate neuron update: drive sum, activation, leaky integration per neuron.
// Depends on lrnu_pkg and lrnu_ram (per-neuron rate store).
//
//   channel  direction  handshake                      payload
//   s_axis   in         s_axis_tvalid/s_axis_tready    tdata: index, 4 drives; tuser: reset
//   m_axis   out        m_axis_tvalid/m_axis_tready    tdata: id, activation, rate
//   cfg      in         cfg_valid/cfg_ready            cfg_index, cfg_data
//
// One item per cycle, unless a held result stalls the pipeline, through eight
// register stages; m_axis_tvalid rises when the item reaches the output register.
// The depth is set by the four multiplies, the logistic table read and the rate
// store read. The rate store read/modify/write closes in the last stage, with
// the output register forwarded to a following item for the same neuron.
// rst clears control state and config; the rate store reads zero per entry until
// written (one valid bit per entry), so there is no clearing pass. Both input
// channels are not ready during rst.
// A result held by m_axis_tready low stalls the whole pipeline; s_axis_tready drops with it.
module leaky_rate_neuron_update_top
  import lrnu_pkg::*;
#(
  parameter int NEURON_COUNT        = NEURON_COUNT_DEF,
  parameter int SIGMOID_TABLE_DEPTH = SIGMOID_TABLE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // neuron_index, direct_drive, excite_drive, inhibit_drive, modulate_drive
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // reset_request
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // neuron_id, activation_value, rate_value
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [Q_W-1:0]        cfg_data
);

  localparam int ID_SPAN    = 2 ** ID_W;
  localparam int RATE_DEPTH = (NEURON_COUNT < ID_SPAN) ? NEURON_COUNT : ID_SPAN;
  localparam int RATE_AW    = (RATE_DEPTH > 1) ? $clog2(RATE_DEPTH) : 1;
  localparam int LUT_AW     = $clog2(SIGMOID_TABLE_DEPTH);
  localparam int LUT_DW     = $clog2(SIGMOID_TABLE_DEPTH + 1);
  localparam int HALF_D     = SIGMOID_TABLE_DEPTH / 2;
  localparam int NSTAGE     = 8;

  localparam logic signed [36:0] X_MIN = -37'sd524288;
  localparam logic signed [36:0] X_MAX = 37'sd524287;

  // configuration
  cfg_t cfg;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.act_mode  <= MODE_LINEAR;
      cfg.gain      <= 16'sd256;
      cfg.bias      <= '0;
      cfg.sig_mid   <= '0;
      cfg.min_rate  <= '0;
      cfg.max_rate  <= 16'sd256;
      cfg.init_rate <= '0;
      cfg.decay     <= 16'd58982;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ACT_MODE:  cfg.act_mode  <= cfg_data[MODE_W-1:0];
        REG_GAIN:      cfg.gain      <= cfg_data;
        REG_BIAS:      cfg.bias      <= cfg_data;
        REG_SIG_MID:   cfg.sig_mid   <= cfg_data;
        REG_MIN_RATE:  cfg.min_rate  <= cfg_data;
        REG_MAX_RATE:  cfg.max_rate  <= cfg_data;
        REG_INIT_RATE: cfg.init_rate <= cfg_data;
        REG_DECAY:     cfg.decay     <= cfg_data;
      endcase
    end
  end

  // logistic table
  logic [Q_W-1:0] lut [SIGMOID_TABLE_DEPTH];

  for (genvar k = 0; k < SIGMOID_TABLE_DEPTH; k++) begin : g_lut
    localparam logic [Q_W-1:0] SAMPLE = logistic_sample(k - HALF_D, SIGMOID_TABLE_DEPTH);
    assign lut[k] = SAMPLE;
  end

  // pipeline control
  logic              ce;
  logic [NSTAGE-1:0] vld;

  assign ce            = !vld[NSTAGE-1] || m_axis_tready;
  assign s_axis_tready = ce && !rst;
  assign m_axis_tvalid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[NSTAGE-2:0], s_axis_tvalid};
    end
  end

  // stage payloads
  logic [ID_W-1:0]        id1, id2, id3, id4, id5, id6, id7, out_id;
  logic                   rq1, rq2, rq3, rq4, rq5, rq6, rq7;
  logic signed [Q_W-1:0]  dd1, de1, di1, dm1;
  logic signed [19:0]     opnd2;
  logic signed [35:0]     prod3;
  logic signed [Q_W-1:0]  lin_t4, lin_t5, lin_t6;
  logic [19:0]            xo4;
  logic [LUT_AW-1:0]      idx5;
  logic [Q_W-1:0]         lv6;
  logic signed [Q_W-1:0]  t7;
  logic                   rng7;
  logic signed [Q_W-1:0]  out_act, out_rate;

  // stage 1 -> 2: drive sum
  logic signed [18:0] drive;
  logic signed [19:0] dmid;

  assign drive = 19'(dd1) + 19'(de1) - 19'(di1) + 19'(dm1) + 19'(cfg.bias);
  assign dmid  = 20'(drive) - 20'(cfg.sig_mid);

  // stage 3 -> 4: linear / relu clamp, sigmoid exponent clamp
  logic signed [27:0] lin_v;
  logic signed [36:0] xneg;
  logic signed [36:0] xs;

  always_comb begin
    lin_v = prod3[35:8];
    if (cfg.act_mode == MODE_RELU && lin_v[27]) begin
      lin_v = '0;
    end
    if (lin_v < 28'(cfg.min_rate)) begin
      lin_v = 28'(cfg.min_rate);
    end
    if (lin_v > 28'(cfg.max_rate)) begin
      lin_v = 28'(cfg.max_rate);
    end
    xneg = -37'(prod3);
    xs   = xneg;
    if (xs < X_MIN) begin
      xs = X_MIN;
    end
    if (xs > X_MAX) begin
      xs = X_MAX;
    end
  end

  // stage 4 -> 5: table index
  logic [20+LUT_DW-1:0] idx_prod;

  assign idx_prod = {{LUT_DW{1'b0}}, xo4} * (20 + LUT_DW)'(SIGMOID_TABLE_DEPTH);

  // stage 6 -> 7: sigmoid target
  logic signed [16:0] span;
  logic signed [33:0] sprod;
  logic signed [18:0] sig_sum;

  assign span    = 17'(cfg.max_rate) - 17'(cfg.min_rate);
  assign sprod   = 34'(span) * 34'($signed({1'b0, lv6}));
  assign sig_sum = 19'(cfg.min_rate) + 19'(sprod >>> 16);

  // rate store
  logic                 ram_we;
  logic [RATE_AW-1:0]   addr6, addr7;
  logic [Q_W-1:0]       ram_rdata;
  logic [RATE_DEPTH-1:0] seen;
  logic signed [Q_W-1:0] rate_next;

  assign addr6  = id6[RATE_AW-1:0];
  assign addr7  = id7[RATE_AW-1:0];
  assign ram_we = ce && vld[6] && rng7;

  lrnu_ram #(
    .WIDTH (Q_W),
    .DEPTH (RATE_DEPTH)
  ) u_rate_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr7),
    .wdata (rate_next),
    .re    (ce),
    .raddr (addr6),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (ram_we) begin
      seen[addr7] <= 1'b1;
    end
  end

  // stage 7 -> out: leaky integration
  logic signed [Q_W-1:0] init_c;
  logic signed [Q_W-1:0] rate_cur;
  logic signed [16:0]    diff;
  logic signed [33:0]    dprod;
  logic signed [18:0]    next_sum;

  always_comb begin
    init_c = cfg.init_rate;
    if (init_c < cfg.min_rate) begin
      init_c = cfg.min_rate;
    end
    if (init_c > cfg.max_rate) begin
      init_c = cfg.max_rate;
    end
    priority if (rq7) begin
      rate_cur = init_c;
    end else if (!rng7) begin
      rate_cur = '0;
    end else if (vld[NSTAGE-1] && out_id == id7) begin
      rate_cur = out_rate;
    end else if (seen[addr7]) begin
      rate_cur = ram_rdata;
    end else begin
      rate_cur = '0;
    end
  end

  assign diff      = 17'(rate_cur) - 17'(t7);
  assign dprod     = 34'(diff) * 34'($signed({1'b0, cfg.decay}));
  assign next_sum  = 19'(t7) + 19'(dprod >>> 16);
  assign rate_next = next_sum[Q_W-1:0];

  always_ff @(posedge clk) begin
    if (ce) begin
      id1 <= s_axis_tdata[7:0];
      dd1 <= s_axis_tdata[23:8];
      de1 <= s_axis_tdata[39:24];
      di1 <= s_axis_tdata[55:40];
      dm1 <= s_axis_tdata[71:56];
      rq1 <= s_axis_tuser;

      id2   <= id1;
      rq2   <= rq1;
      opnd2 <= (cfg.act_mode == MODE_SIGMOID) ? dmid : 20'(drive);

      id3   <= id2;
      rq3   <= rq2;
      prod3 <= 36'(cfg.gain) * 36'(opnd2);

      id4    <= id3;
      rq4    <= rq3;
      lin_t4 <= lin_v[Q_W-1:0];
      xo4    <= xs[19:0] + 20'h80000;

      id5    <= id4;
      rq5    <= rq4;
      lin_t5 <= lin_t4;
      idx5   <= idx_prod[20 +: LUT_AW];

      id6    <= id5;
      rq6    <= rq5;
      lin_t6 <= lin_t5;
      lv6    <= lut[idx5];

      id7  <= id6;
      rq7  <= rq6;
      rng7 <= {1'b0, id6} < (ID_W + 1)'(RATE_DEPTH);
      t7   <= (cfg.act_mode == MODE_SIGMOID) ? sig_sum[Q_W-1:0] : lin_t6;

      out_id   <= id7;
      out_act  <= t7;
      out_rate <= rate_next;
    end
  end

  assign m_axis_tdata = {out_rate, out_act, out_id};

endmodule

// ===== src/lrnu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Read-first: a read at the written address returns the old word.
module lrnu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/lrnu_checker.sv =====
// Port-level checks for leaky_rate_neuron_update_top, attached by bind.
// Depends on lrnu_pkg.
module lrnu_checker
  import lrnu_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic                  s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [Q_W-1:0]        cfg_data
);

  // no item leaves the eight-stage pipeline after reset before passing every stage
  a_reset_latency: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid ##1 !m_axis_tvalid ##1 !m_axis_tvalid ##1 !m_axis_tvalid
        ##1 !m_axis_tvalid ##1 !m_axis_tvalid ##1 !m_axis_tvalid ##1 !m_axis_tvalid)
    else $error("result item too early after reset");

  // input side only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result item changed");

endmodule

bind leaky_rate_neuron_update_top lrnu_checker u_lrnu_checker (.*);

// ===== tb/tb.sv =====
// Self-checking bench for leaky_rate_neuron_update_top: drives stream items and register
// writes, predicts activation and rate per neuron, and checks every result item.
// Depends on lrnu_pkg and the top-level RTL.
`timescale 1ns / 1ps

module tb
  import lrnu_pkg::*;
();

  localparam int NEURONS        = NEURON_COUNT_DEF;
  localparam int SIG_DEPTH      = SIGMOID_TABLE_DEPTH_DEF;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PRINT_LIMIT    = 40;

  typedef struct {
    logic [ID_W-1:0]       idx;
    logic signed [Q_W-1:0] direct, excite, inhibit, modulate;
    logic                  reload;
  } nrn_item_t;

  typedef struct {
    logic [ID_W-1:0]       id;
    logic signed [Q_W-1:0] act, rate;
  } nrn_result_t;

  typedef struct {
    logic [MODE_W-1:0]     mode;
    logic signed [Q_W-1:0] gain, bias, mid, lo, hi, init;
    logic [Q_W-1:0]        decay;
  } nrn_cfg_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_ACT_MODE;
  logic [Q_W-1:0]        cfg_data = '0;

  nrn_cfg_t              cur;
  logic signed [Q_W-1:0] rate_mem [NEURONS];
  logic [15:0]           logistic_lut [SIG_DEPTH];
  nrn_result_t           pending_results[$];
  int                    error_count = 0;
  int                    quiet_cycles = 0;
  bit                    no_idle = 1'b0;

  leaky_rate_neuron_update_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #6 clk = ~clk;

  // 1/(1+e^x), x = 16*m/depth, floored Q0.16; e^-|x| from a Q30 series squared four times
  function automatic logic [15:0] logistic_point(input int m);
    longint unsigned one, u, acc, term, e, f, n;
    one  = 64'd1 << 30;
    u    = (longint'(m < 0 ? -m : m) << 30) / SIG_DEPTH;
    acc  = one;
    term = one;
    for (n = 1; n <= 24; n++) begin
      term = ((term * u) >> 30) / n;
      acc  = acc + term;
    end
    e = (64'd1 << 60) / acc;
    repeat (4) e = (e * e) >> 30;
    if (m >= 0) begin
      f = (e << 16) / (one + e);
    end else begin
      f = (64'd1 << 46) / (one + e);
    end
    if (f > 64'd65535) begin
      f = 64'd65535;
    end
    return f[15:0];
  endfunction

  function automatic nrn_cfg_t reset_cfg();
    nrn_cfg_t c;
    c.mode  = MODE_LINEAR;
    c.gain  = 16'sh0100;
    c.bias  = '0;
    c.mid   = '0;
    c.lo    = '0;
    c.hi    = 16'sh0100;
    c.init  = '0;
    c.decay = 16'd58982;
    return c;
  endfunction

  function automatic void apply_reg(input cfg_reg_t r, input logic [Q_W-1:0] d);
    case (r)
      REG_ACT_MODE:  cur.mode  = d[MODE_W-1:0];
      REG_GAIN:      cur.gain  = d;
      REG_BIAS:      cur.bias  = d;
      REG_SIG_MID:   cur.mid   = d;
      REG_MIN_RATE:  cur.lo    = d;
      REG_MAX_RATE:  cur.hi    = d;
      REG_INIT_RATE: cur.init  = d;
      REG_DECAY:     cur.decay = d;
      default: ;
    endcase
  endfunction

  // Activation target and leaky rate update; advances the neuron's stored rate.
  function automatic nrn_result_t predict_update(input nrn_item_t it);
    nrn_result_t res;
    longint lo, hi, rate, drive, x, tgt, nxt;
    int idx;
    bit in_pop;
    in_pop = int'(it.idx) < NEURONS;
    lo   = longint'(cur.lo);
    hi   = longint'(cur.hi);
    rate = in_pop ? longint'(rate_mem[it.idx]) : 0;
    if (it.reload) begin
      rate = longint'(cur.init);
      if (rate < lo) rate = lo;
      if (rate > hi) rate = hi;
    end
    drive = longint'(it.direct) + longint'(it.excite) - longint'(it.inhibit)
          + longint'(it.modulate) + longint'(cur.bias);
    if (cur.mode == MODE_SIGMOID) begin
      x = -(longint'(cur.gain) * (drive - longint'(cur.mid)));
      if (x < -(longint'(8) << 16)) x = -(longint'(8) << 16);
      if (x > (longint'(8) << 16) - 1) x = (longint'(8) << 16) - 1;
      idx = int'(((x + (longint'(8) << 16)) * SIG_DEPTH) >>> 20);
      tgt = lo + (((hi - lo) * longint'(logistic_lut[idx])) >>> 16);
    end else begin
      tgt = (longint'(cur.gain) * drive) >>> 8;
      if (cur.mode == MODE_RELU && tgt < 0) tgt = 0;
      if (tgt < lo) tgt = lo;
      if (tgt > hi) tgt = hi;
    end
    nxt = tgt + (((rate - tgt) * longint'(cur.decay)) >>> 16);
    // indices past the population read zero and leave the store alone
    if (in_pop) rate_mem[it.idx] = nxt[15:0];
    res.id   = it.idx;
    res.act  = tgt[15:0];
    res.rate = nxt[15:0];
    return res;
  endfunction

  function automatic nrn_item_t mk_item(input logic [7:0] idx, input logic [15:0] d,
                                        input logic [15:0] e, input logic [15:0] i,
                                        input logic [15:0] m, input logic r);
    nrn_item_t it;
    it.idx      = idx;
    it.direct   = d;
    it.excite   = e;
    it.inhibit  = i;
    it.modulate = m;
    it.reload   = r;
    return it;
  endfunction

  function automatic logic [15:0] rand_q8(input int small_pct);
    if ($urandom_range(0, 99) < small_pct) begin
      return 16'(int'($urandom_range(0, 1023)) - 512);
    end
    return 16'($urandom);
  endfunction

  function automatic nrn_item_t random_item();
    logic [7:0] idx;
    idx = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
    return mk_item(idx, rand_q8(75), rand_q8(75), rand_q8(75), rand_q8(75),
                   $urandom_range(0, 7) == 0);
  endfunction

  function automatic nrn_cfg_t random_cfg();
    nrn_cfg_t c;
    logic signed [15:0] a, b;
    c.mode  = MODE_W'($urandom_range(0, 3));
    c.gain  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(int'($urandom_range(0, 767)) - 256);
    c.bias  = rand_q8(80);
    c.mid   = rand_q8(80);
    c.init  = 16'($urandom);
    c.decay = 16'($urandom);
    a = rand_q8(30);
    b = rand_q8(30);
    if ((a > b) == ($urandom_range(0, 7) != 0)) begin
      c.lo = b;
      c.hi = a;
    end else begin
      c.lo = a;
      c.hi = b;
    end
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // leaves cfg_valid high; set_config lowers it after the last register
  task automatic write_reg(input cfg_reg_t r, input logic [Q_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(r, d);
    @(negedge clk);
  endtask

  task automatic set_config(input nrn_cfg_t c);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    write_reg(REG_ACT_MODE,  {{(Q_W-MODE_W){1'b0}}, c.mode});
    write_reg(REG_GAIN,      c.gain);
    write_reg(REG_BIAS,      c.bias);
    write_reg(REG_SIG_MID,   c.mid);
    write_reg(REG_MIN_RATE,  c.lo);
    write_reg(REG_MAX_RATE,  c.hi);
    write_reg(REG_INIT_RATE, c.init);
    write_reg(REG_DECAY,     c.decay);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(input nrn_item_t it);
    int idle;
    idle = no_idle ? 0 : $urandom_range(0, 4);
    if (idle > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.modulate, it.inhibit, it.excite, it.direct, it.idx};
    s_axis_tuser  <= it.reload;
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(predict_update(it));
    @(negedge clk);
  endtask

  task automatic test_reset_defaults();
    send_item(mk_item(8'd0,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_item(mk_item(8'd255, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0));
    send_item(mk_item(8'd255, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 1'b1));
    send_item(mk_item(8'd0,   16'h0100, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_item(mk_item(8'd0,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
  endtask

  task automatic test_modes();
    nrn_cfg_t c;
    logic [MODE_W-1:0] modes [4];
    modes = '{MODE_LINEAR, MODE_RELU, MODE_SIGMOID, 2'd3};  // code three runs as linear
    c = reset_cfg();
    c.gain  = 16'sh0180;
    c.bias  = 16'sh0010;
    c.mid   = 16'sh0020;
    c.lo    = 16'shFE00;
    c.hi    = 16'sh0300;
    c.init  = 16'sh0100;
    c.decay = 16'h8000;
    foreach (modes[k]) begin
      c.mode = modes[k];
      set_config(c);
      send_item(mk_item(8'd7, 16'h0200, 16'h0040, 16'h0010, 16'h0000, 1'b0));
      send_item(mk_item(8'd7, 16'hFD00, 16'h0000, 16'h0100, 16'h0000, 1'b0));
      send_item(mk_item(8'd7, 16'h0020, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    end
  endtask

  // lower bound above upper bound: clamps land on the upper bound
  task automatic test_inverted_clamp();
    nrn_cfg_t c;
    c = reset_cfg();
    c.lo   = 16'sh0200;
    c.hi   = 16'shFF00;
    c.init = 16'sh7000;
    set_config(c);
    send_item(mk_item(8'd9, 16'h1000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    send_item(mk_item(8'd9, 16'hF000, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    c.mode = MODE_SIGMOID;
    set_config(c);
    send_item(mk_item(8'd10, 16'h0080, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    send_item(mk_item(8'd10, 16'hFF80, 16'h0000, 16'h0000, 16'h0000, 1'b0));
  endtask

  task automatic test_decay_extremes();
    nrn_cfg_t c;
    c = reset_cfg();
    c.lo    = 16'shC000;
    c.hi    = 16'sh4000;
    c.decay = 16'h0000;
    set_config(c);
    send_item(mk_item(8'd20, 16'h0123, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    c.gain  = 16'sh8000;
    c.bias  = 16'sh7FFF;
    c.lo    = 16'sh8000;
    c.hi    = 16'sh7FFF;
    c.init  = 16'sh8000;
    c.decay = 16'hFFFF;
    set_config(c);
    send_item(mk_item(8'd21, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    send_item(mk_item(8'd21, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0));
  endtask

  task automatic test_random_traffic();
    nrn_cfg_t c;
    for (int ph = 0; ph < 10; ph++) begin
      c = random_cfg();
      if (ph == 0) begin
        c.mode  = MODE_LINEAR;
        c.gain  = 16'sh8000;
        c.lo    = 16'sh8000;
        c.hi    = 16'sh7FFF;
        c.decay = 16'hFFFF;
      end
      if (ph == 5) begin
        c.mode = MODE_SIGMOID;
        c.gain = 16'(int'($urandom_range(0, 511)) - 128);
      end
      if (ph == 9) begin
        c.mode  = MODE_SIGMOID;
        c.gain  = 16'sh7FFF;
        c.mid   = 16'sh7FFF;
        c.lo    = 16'sh7FFF;
        c.hi    = 16'sh8000;
        c.decay = 16'h0000;
      end
      set_config(c);
      no_idle = (ph == 3 || ph == 7);
      for (int k = 0; k < 125; k++) send_item(random_item());
    end
    no_idle = 1'b0;
  endtask

  initial begin : result_monitor
    int stall;
    nrn_result_t got;
    nrn_result_t want;
    wait (!rst);
    @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      got.id   = m_axis_tdata[7:0];
      got.act  = m_axis_tdata[23:8];
      got.rate = m_axis_tdata[39:24];
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected item for neuron %0d", got.id));
      end else begin
        want = pending_results.pop_front();
        if (got.id !== want.id)
          report_mismatch($sformatf("neuron_id got %0d want %0d", got.id, want.id));
        if (got.act !== want.act)
          report_mismatch($sformatf("neuron %0d activation got %h want %h",
                                    want.id, got.act, want.act));
        if (got.rate !== want.rate)
          report_mismatch($sformatf("neuron %0d rate got %h want %h",
                                    want.id, got.rate, want.rate));
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (!rst) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TIMEOUT: no handshake for %0d cycles, %0d items outstanding",
                 WATCHDOG_LIMIT, pending_results.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    cur = reset_cfg();
    foreach (rate_mem[k]) rate_mem[k] = '0;
    foreach (logistic_lut[k]) logistic_lut[k] = logistic_point(k - SIG_DEPTH / 2);
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_modes();
    test_inverted_clamp();
    test_decay_extremes();
    test_random_traffic();
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/lrnu_pkg.sv
src/lrnu_ram.sv
src/leaky_rate_neuron_update_top.sv
src/lrnu_checker.sv
tb/tb.sv
